### design/dns_question_section_parser_assert.svh
// assertion macros for the dns question section parser
`ifndef DNS_QUESTION_SECTION_PARSER_ASSERT_SVH
`define DNS_QUESTION_SECTION_PARSER_ASSERT_SVH

// property checked at every clock edge out of reset
`define DNSQP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define DNSQP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/dnsqp_pkg.sv
// shared types and constants for the dns question section parser
package dnsqp_pkg;

    localparam int MAX_LABEL_LEN = 63;
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [3:0] ID_END = 4'd2;
    localparam logic [3:0] FLAGS_END = 4'd4;
    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [1:0] TAIL_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_LEN    = 3'd2,
        PH_BODY   = 3'd3,
        PH_TAIL   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_QDONE = 2'd1,
        KIND_HDONE = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase       phase;
        logic [3:0]   hdr_cnt;
        logic [15:0]  id;
        logic [15:0]  flags;
        logic [63:0]  counts;
        logic [15:0]  qcnt;
        logic [5:0]   label_rem;
        logic         label_seen;
        logic [23:0]  tail_shift;
        logic [1:0]   tail_cnt;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_IDLE, hdr_cnt: '0, id: '0, flags: '0, counts: '0,
        qcnt: '0, label_rem: '0, label_seen: 1'b0, tail_shift: '0, tail_cnt: '0
    };

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   name_char;
        logic [15:0]  question_index;
        logic [15:0]  query_type;
        logic [15:0]  query_class;
        logic [15:0]  message_id;
        logic [15:0]  header_flags;
        logic [15:0]  question_total;
        logic [15:0]  answer_total;
        logic [15:0]  authority_total;
        logic [15:0]  additional_total;
        logic         message_last;
    } t_result;

    localparam t_result RESULT_NONE = '{
        kind: KIND_CHAR, name_char: '0, question_index: '0, query_type: '0,
        query_class: '0, message_id: '0, header_flags: '0, question_total: '0,
        answer_total: '0, authority_total: '0, additional_total: '0,
        message_last: 1'b0
    };

endpackage

### design/dnsqp_if.sv
// byte input and result output channel interfaces
interface dnsqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       msg_start;

    modport source (output valid, output in_byte, output msg_start, input ready);
    modport sink (input valid, input in_byte, input msg_start, output ready);
endinterface

interface dnsqp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  name_char;
    logic [15:0] question_index;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [15:0] message_id;
    logic [15:0] header_flags;
    logic [15:0] question_total;
    logic [15:0] answer_total;
    logic [15:0] authority_total;
    logic [15:0] additional_total;
    logic        message_last;

    modport source (
        output valid, output result_kind, output name_char, output question_index,
        output query_type, output query_class, output message_id, output header_flags,
        output question_total, output answer_total, output authority_total,
        output additional_total, output message_last, input ready
    );
    modport sink (
        input valid, input result_kind, input name_char, input question_index,
        input query_type, input query_class, input message_id, input header_flags,
        input question_total, input answer_total, input authority_total,
        input additional_total, input message_last, output ready
    );
endinterface

### design/dnsqp_step.sv
// per-byte parse step: next state and optional result
module dnsqp_step import dnsqp_pkg::*; (
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_res,
    output logic       o_res_valid
);

    t_state     cur;
    t_state     nxt;
    logic [3:0] hdr_next;
    logic [15:0] q_next;

    always_comb begin
        cur = i_state;
        if (i_start) begin
            cur = STATE_RESET;
            cur.phase = PH_HEADER;
        end
        nxt = cur;
        o_res = RESULT_NONE;
        o_res_valid = 1'b0;
        hdr_next = cur.hdr_cnt + 4'd1;
        q_next = cur.qcnt + 16'd1;

        case (cur.phase)
            PH_HEADER: begin
                if (cur.hdr_cnt < ID_END) begin
                    nxt.id = {cur.id[7:0], i_byte};
                end else if (cur.hdr_cnt < FLAGS_END) begin
                    nxt.flags = {cur.flags[7:0], i_byte};
                end else begin
                    nxt.counts = {cur.counts[55:0], i_byte};
                end
                nxt.hdr_cnt = hdr_next;
                if (hdr_next >= HEADER_BYTES) begin
                    o_res_valid = 1'b1;
                    o_res.kind = KIND_HDONE;
                    o_res.message_id = nxt.id;
                    o_res.header_flags = nxt.flags;
                    o_res.question_total = nxt.counts[63:48];
                    o_res.answer_total = nxt.counts[47:32];
                    o_res.authority_total = nxt.counts[31:16];
                    o_res.additional_total = nxt.counts[15:0];
                    nxt.qcnt = '0;
                    if (nxt.counts[63:48] == 16'd0) begin
                        o_res.message_last = 1'b1;
                        nxt.phase = PH_IDLE;
                    end else begin
                        nxt.phase = PH_LEN;
                        nxt.label_seen = 1'b0;
                        nxt.label_rem = '0;
                        nxt.tail_shift = '0;
                        nxt.tail_cnt = '0;
                    end
                end
            end
            PH_LEN: begin
                if (i_byte == 8'd0) begin
                    nxt.phase = PH_TAIL;
                    nxt.tail_shift = '0;
                    nxt.tail_cnt = '0;
                end else if (i_byte > 8'(MAX_LABEL_LEN)) begin
                    o_res_valid = 1'b1;
                    o_res.kind = KIND_ERROR;
                    o_res.question_index = cur.qcnt;
                    o_res.message_last = 1'b1;
                    nxt.phase = PH_IDLE;
                end else begin
                    nxt.label_rem = i_byte[5:0];
                    nxt.phase = PH_BODY;
                    nxt.label_seen = 1'b1;
                    if (cur.label_seen) begin
                        o_res_valid = 1'b1;
                        o_res.kind = KIND_CHAR;
                        o_res.name_char = DOT_CHAR;
                        o_res.question_index = cur.qcnt;
                    end
                end
            end
            PH_BODY: begin
                o_res_valid = 1'b1;
                o_res.kind = KIND_CHAR;
                o_res.name_char = i_byte;
                o_res.question_index = cur.qcnt;
                nxt.label_rem = cur.label_rem - 6'd1;
                if (nxt.label_rem == 6'd0) begin
                    nxt.phase = PH_LEN;
                end
            end
            PH_TAIL: begin
                if (cur.tail_cnt < TAIL_LAST) begin
                    nxt.tail_shift = {cur.tail_shift[15:0], i_byte};
                    nxt.tail_cnt = cur.tail_cnt + 2'd1;
                end else begin
                    o_res_valid = 1'b1;
                    o_res.kind = KIND_QDONE;
                    o_res.question_index = cur.qcnt;
                    o_res.query_type = cur.tail_shift[23:8];
                    o_res.query_class = {cur.tail_shift[7:0], i_byte};
                    nxt.qcnt = q_next;
                    nxt.tail_shift = '0;
                    nxt.tail_cnt = '0;
                    if (q_next == cur.counts[63:48]) begin
                        o_res.message_last = 1'b1;
                        nxt.phase = PH_IDLE;
                    end else begin
                        nxt.phase = PH_LEN;
                        nxt.label_seen = 1'b0;
                        nxt.label_rem = '0;
                    end
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        o_state = nxt;
    end

endmodule

### design/dns_question_section_parser.sv
// dns question section parser top level: input stage, parse state, result register
//
// channel   dir  payload
// i_in      in   in_byte, msg_start
// o_out     out  result_kind, name_char, question_index, query_type, query_class,
//                message_id, header_flags, four header counts, message_last
//
// one byte per cycle sustained while o_out is ready; each byte goes input register, parse step, result register
// an input register and a result register each hold one item, so one byte is held
// while a result waits; the parse state advances only when the result slot frees
// synchronous active-low reset empties both registers and returns the parser to idle
`include "dns_question_section_parser_assert.svh"

module dns_question_section_parser import dnsqp_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    dnsqp_in_if.sink    i_in,
    dnsqp_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       n_out_valid;
    logic       advance;

    dnsqp_step u_step (
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res       (n_out),
        .o_res_valid (n_out_valid)
    );

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state <= STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_state <= n_state;
                r_out_valid <= n_out_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_start <= i_in.msg_start;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.result_kind = r_out.kind;
    assign o_out.name_char = r_out.name_char;
    assign o_out.question_index = r_out.question_index;
    assign o_out.query_type = r_out.query_type;
    assign o_out.query_class = r_out.query_class;
    assign o_out.message_id = r_out.message_id;
    assign o_out.header_flags = r_out.header_flags;
    assign o_out.question_total = r_out.question_total;
    assign o_out.answer_total = r_out.answer_total;
    assign o_out.authority_total = r_out.authority_total;
    assign o_out.additional_total = r_out.additional_total;
    assign o_out.message_last = r_out.message_last;

    `DNSQP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_in_valid && !r_out_valid, "registers not empty after reset")
    `DNSQP_ASSERT(a_error_last, r_out_valid && r_out.kind == KIND_ERROR |-> r_out.message_last, "error result not last")
    `DNSQP_ASSERT(a_char_not_last, r_out_valid && r_out.kind == KIND_CHAR |-> !r_out.message_last, "name char marked last")
    `DNSQP_ASSERT(a_empty_hdr_last, r_out_valid && r_out.kind == KIND_HDONE && r_out.question_total == 16'd0 |-> r_out.message_last, "header without questions not last")
    `DNSQP_ASSERT(a_header_count, r_state.phase == PH_HEADER |-> r_state.hdr_cnt < HEADER_BYTES, "header byte count overran")

endmodule

### sim/dns_question_section_parser_test.sv
// testbench for the dns question section parser: byte driver, result monitor, predictor
module dns_question_section_parser_test;
    import dnsqp_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int BYTES_PER_PHASE = 175;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dnsqp_in_if  byte_ch ();
    dnsqp_out_if result_ch ();

    dns_question_section_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (result_ch.source)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_byte_item bytes_to_send[$];
    t_result    results_due[$];
    t_byte_item send_byte;
    t_result    due_result;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         counted_bytes = 0;
    int         fail_count = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;

    // parser state mirrored by the predictor
    t_phase      parse_phase = PH_IDLE;
    logic [3:0]  header_cnt = '0;
    logic [15:0] msg_id = '0;
    logic [15:0] msg_flags = '0;
    logic [63:0] msg_counts = '0;
    logic [15:0] question_idx = '0;
    logic [5:0]  label_left = '0;
    logic        label_begun = 1'b0;
    logic [23:0] tail_bytes = '0;
    logic [1:0]  tail_cnt = '0;

    function automatic void open_name();
        parse_phase = PH_LEN;
        label_begun = 1'b0;
        label_left = '0;
        tail_bytes = '0;
        tail_cnt = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] data, input logic start);
        t_result res;
        logic    emit;
        res = RESULT_NONE;
        emit = 1'b0;
        if (start) begin
            header_cnt = '0;
            msg_id = '0;
            msg_flags = '0;
            msg_counts = '0;
            question_idx = '0;
            label_left = '0;
            label_begun = 1'b0;
            tail_bytes = '0;
            tail_cnt = '0;
            parse_phase = PH_HEADER;
        end
        case (parse_phase)
            PH_HEADER: begin
                if (header_cnt < ID_END) begin
                    msg_id = {msg_id[7:0], data};
                end else if (header_cnt < FLAGS_END) begin
                    msg_flags = {msg_flags[7:0], data};
                end else begin
                    msg_counts = {msg_counts[55:0], data};
                end
                header_cnt = header_cnt + 4'd1;
                if (header_cnt == HEADER_BYTES) begin
                    emit = 1'b1;
                    res.kind = KIND_HDONE;
                    res.message_id = msg_id;
                    res.header_flags = msg_flags;
                    res.question_total = msg_counts[63:48];
                    res.answer_total = msg_counts[47:32];
                    res.authority_total = msg_counts[31:16];
                    res.additional_total = msg_counts[15:0];
                    question_idx = '0;
                    if (msg_counts[63:48] == 16'd0) begin
                        res.message_last = 1'b1;
                        parse_phase = PH_IDLE;
                    end else begin
                        open_name();
                    end
                end
            end
            PH_LEN: begin
                if (data == 8'd0) begin
                    parse_phase = PH_TAIL;
                    tail_bytes = '0;
                    tail_cnt = '0;
                end else if (data > MAX_LABEL_LEN) begin
                    emit = 1'b1;
                    res.kind = KIND_ERROR;
                    res.question_index = question_idx;
                    res.message_last = 1'b1;
                    parse_phase = PH_IDLE;
                end else begin
                    label_left = data[5:0];
                    parse_phase = PH_BODY;
                    if (label_begun) begin
                        emit = 1'b1;
                        res.kind = KIND_CHAR;
                        res.name_char = DOT_CHAR;
                        res.question_index = question_idx;
                    end
                    label_begun = 1'b1;
                end
            end
            PH_BODY: begin
                emit = 1'b1;
                res.kind = KIND_CHAR;
                res.name_char = data;
                res.question_index = question_idx;
                label_left = label_left - 6'd1;
                if (label_left == 6'd0) parse_phase = PH_LEN;
            end
            PH_TAIL: begin
                if (tail_cnt < TAIL_LAST) begin
                    tail_bytes = {tail_bytes[15:0], data};
                    tail_cnt = tail_cnt + 2'd1;
                end else begin
                    emit = 1'b1;
                    res.kind = KIND_QDONE;
                    res.question_index = question_idx;
                    res.query_type = tail_bytes[23:8];
                    res.query_class = {tail_bytes[7:0], data};
                    question_idx = question_idx + 16'd1;
                    if (question_idx == msg_counts[63:48]) begin
                        res.message_last = 1'b1;
                        parse_phase = PH_IDLE;
                        tail_bytes = '0;
                        tail_cnt = '0;
                    end else begin
                        open_name();
                    end
                end
            end
            default: begin
            end
        endcase
        if (emit) results_due.insert(results_due.size(), res);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic start, input logic counted);
        t_byte_item item;
        item.data = data;
        item.start = start;
        bytes_to_send.insert(bytes_to_send.size(), item);
        if (counted) counted_bytes++;
    endtask

    task automatic push_word(input logic [15:0] word, input logic start);
        queue_byte(word[15:8], start, 1'b1);
        queue_byte(word[7:0], 1'b0, 1'b1);
    endtask

    // one message: header, questions, sometimes cut short, a bad label or trailing bytes
    task automatic add_message();
        int          n_q;
        int          q_hdr;
        int          r;
        int          len;
        logic [15:0] word;
        r = $urandom_range(99);
        n_q = (r < 10) ? 0 : (r < 80) ? $urandom_range(2, 1) : $urandom_range(5, 3);
        q_hdr = n_q;
        if ($urandom_range(99) < 8) q_hdr = $urandom_range(65535, n_q + 1);
        for (int i = 0; i < 6; i++) begin
            word = (i == 2) ? q_hdr[15:0] : 16'($urandom);
            push_word(word, i == 0);
        end
        for (int q = 0; q < n_q; q++) begin
            repeat ($urandom_range(3)) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    queue_byte(8'($urandom_range(255, MAX_LABEL_LEN + 1)), 1'b0, 1'b1);
                    return;
                end
                if (r < 6) return;
                len = (r < 11) ? MAX_LABEL_LEN : $urandom_range(8, 1);
                queue_byte(8'(len), 1'b0, 1'b1);
                repeat (len) begin
                    if ($urandom_range(1)) begin
                        queue_byte(8'($urandom_range(255)), 1'b0, 1'b1);
                    end else begin
                        queue_byte(8'($urandom_range(8'h7A, 8'h61)), 1'b0, 1'b1);
                    end
                end
            end
            queue_byte(8'd0, 1'b0, 1'b1);
            push_word(16'($urandom), 1'b0);
            push_word(16'($urandom), 1'b0);
        end
        if (q_hdr == n_q && $urandom_range(99) < 20) begin
            repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        end
    endtask

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = '0;
        byte_ch.msg_start = 1'b0;
        result_ch.ready = 1'b0;
    end

    initial begin
        // idle byte, header with no questions, label too long, idle byte after error
        queue_byte(8'hFF, 1'b0, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0000, 1'b1);
        push_word(16'h0000, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        queue_byte(8'(MAX_LABEL_LEN + 1), 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 47;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 47;
                end
                default: begin
                    send_idle_pct = 17;
                    stall_pct = 17;
                end
            endcase
            while (counted_bytes < (p + 1) * BYTES_PER_PHASE) add_message();
            while (bytes_to_send.size() != 0) @(posedge i_clk);
        end
        while (byte_ch.valid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.in_byte, byte_ch.msg_start);
            if (!byte_ch.valid || byte_ch.ready) begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    send_byte = bytes_to_send.pop_front();
                    byte_ch.valid <= 1'b1;
                    byte_ch.in_byte <= send_byte.data;
                    byte_ch.msg_start <= send_byte.start;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing due");
                end else begin
                    due_result = results_due.pop_front();
                    check_field("result_kind", 16'(result_ch.result_kind),
                                16'(due_result.kind));
                    check_field("name_char", 16'(result_ch.name_char),
                                16'(due_result.name_char));
                    check_field("question_index", result_ch.question_index,
                                due_result.question_index);
                    check_field("query_type", result_ch.query_type, due_result.query_type);
                    check_field("query_class", result_ch.query_class, due_result.query_class);
                    check_field("message_id", result_ch.message_id, due_result.message_id);
                    check_field("header_flags", result_ch.header_flags,
                                due_result.header_flags);
                    check_field("question_total", result_ch.question_total,
                                due_result.question_total);
                    check_field("answer_total", result_ch.answer_total,
                                due_result.answer_total);
                    check_field("authority_total", result_ch.authority_total,
                                due_result.authority_total);
                    check_field("additional_total", result_ch.additional_total,
                                due_result.additional_total);
                    check_field("message_last", 16'(result_ch.message_last),
                                16'(due_result.message_last));
                end
            end
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
            || (bytes_to_send.size() == 0 && results_due.size() == 0 && !byte_ch.valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
